### sv/ps2mpt_pkg.sv
package ps2mpt_pkg;

  // Widths fixed by the register map and the byte stream.
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int BYTE_W       = 8;
  localparam int BUTTON_W     = 3;

  // Default coordinate width and register reset values.
  localparam int COORD_BITS_DEFAULT = 12;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 12'd80;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 12'd25;

  // Header bit that is always set in a valid first byte of a packet.
  localparam logic [BYTE_W-1:0] HEADER_MARK = 8'h08;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  // Which byte of the three-byte packet is expected next.
  typedef enum logic [1:0] {
    SLOT_HEADER = 2'd0,
    SLOT_XDELTA = 2'd1,
    SLOT_YDELTA = 2'd2
  } byte_slot_t;

endpackage

### sv/ps2_mouse_packet_tracker_core.sv
// Latency: a result is valid in the cycle after the transfer of the third packet byte.
// Throughput: one byte per cycle while no result waits; a byte is taken while a result waits
// only in the same cycle that out_ready takes it, since that frees the result register.
// Reset (rst_n low, synchronous): packet assembly restarts at the header, the cursor
// goes to column 0 and row 0, buttons clear, and the screen size returns to 80 x 25.
module ps2_mouse_packet_tracker_core #(
  parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,

  // Received bytes from the controller.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_from_aux,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]      in_rx_byte,

  // Cursor position and buttons, one transfer per completed packet.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COORD_BITS-1:0]              out_pos_x,
  output logic [COORD_BITS-1:0]              out_pos_y,
  output logic [ps2mpt_pkg::BUTTON_W-1:0]    out_button_bits,

  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ps2mpt_pkg::CFG_W-1:0]       cfg_wdata
);

  // The arithmetic width holds the wider of the cursor and the screen size, plus
  // one bit for the signed delta reach and one sign bit.
  localparam int CALC_W = ((COORD_BITS > ps2mpt_pkg::CFG_W) ? COORD_BITS
                                                             : ps2mpt_pkg::CFG_W) + 2;
  localparam logic [CALC_W-1:0] COORD_MAX = CALC_W'((1 << COORD_BITS) - 1);

  // Clamp a signed candidate coordinate to 0 .. size-1, where the upper limit is
  // also capped at the largest coordinate and a zero size pins the result at 0.
  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [CALC_W-1:0]       v,
    input logic [ps2mpt_pkg::CFG_W-1:0]   size
  );
    logic [CALC_W-1:0] limit;
    logic [COORD_BITS-1:0] res;
    if (size == '0) begin
      limit = '0;
    end else begin
      limit = CALC_W'(size) - CALC_W'(1);
    end
    if (limit > COORD_MAX) begin
      limit = COORD_MAX;
    end
    if (v[CALC_W-1]) begin
      res = '0;
    end else if (CALC_W'(v) > limit) begin
      res = limit[COORD_BITS-1:0];
    end else begin
      res = v[COORD_BITS-1:0];
    end
    return res;
  endfunction

  // Configuration registers.
  logic [ps2mpt_pkg::CFG_W-1:0] screen_width_r;
  logic [ps2mpt_pkg::CFG_W-1:0] screen_height_r;

  // Packet assembly and cursor state.
  ps2mpt_pkg::byte_slot_t byte_slot_r, byte_slot_nxt;
  logic [ps2mpt_pkg::BYTE_W-1:0]   header_byte_r, header_byte_nxt;
  logic [ps2mpt_pkg::BYTE_W-1:0]   x_delta_byte_r, x_delta_byte_nxt;
  logic [COORD_BITS-1:0]           cursor_col_r, cursor_col_nxt;
  logic [COORD_BITS-1:0]           cursor_row_r, cursor_row_nxt;
  logic [ps2mpt_pkg::BUTTON_W-1:0] held_buttons_r, held_buttons_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt;

  logic in_xfer;
  logic byte_is_mouse;
  logic header_ok;
  logic packet_done;
  logic signed [CALC_W-1:0] dx_ext;
  logic signed [CALC_W-1:0] dy_ext;
  logic signed [CALC_W-1:0] nx;
  logic signed [CALC_W-1:0] ny;

  // The result register is free when empty or when its result leaves this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign byte_is_mouse = in_xfer && in_from_aux;
  assign header_ok     = (in_rx_byte & ps2mpt_pkg::HEADER_MARK) != '0;

  // Next packet slot. Bytes from the keyboard side leave everything alone. A
  // first byte without the header mark is dropped, which realigns the stream.
  always_comb begin
    byte_slot_nxt = byte_slot_r;
    if (byte_is_mouse) begin
      unique case (byte_slot_r)
        ps2mpt_pkg::SLOT_XDELTA: byte_slot_nxt = ps2mpt_pkg::SLOT_YDELTA;
        ps2mpt_pkg::SLOT_YDELTA: byte_slot_nxt = ps2mpt_pkg::SLOT_HEADER;
        default: begin
          if (header_ok) begin
            byte_slot_nxt = ps2mpt_pkg::SLOT_XDELTA;
          end
        end
      endcase
    end
  end

  // Deltas are plain signed bytes; the ninth sign bits and overflow bits of the
  // header are not used. Screen rows grow downward, so dy is subtracted.
  assign dx_ext = $signed({{(CALC_W - ps2mpt_pkg::BYTE_W){x_delta_byte_r[7]}},
                           x_delta_byte_r});
  assign dy_ext = $signed({{(CALC_W - ps2mpt_pkg::BYTE_W){in_rx_byte[7]}},
                           in_rx_byte});
  assign nx = $signed({{(CALC_W - COORD_BITS){1'b0}}, cursor_col_r}) + dx_ext;
  assign ny = $signed({{(CALC_W - COORD_BITS){1'b0}}, cursor_row_r}) - dy_ext;

  assign packet_done = byte_is_mouse && (byte_slot_r == ps2mpt_pkg::SLOT_YDELTA);

  // Datapath and result.
  always_comb begin
    header_byte_nxt  = header_byte_r;
    x_delta_byte_nxt = x_delta_byte_r;
    cursor_col_nxt   = cursor_col_r;
    cursor_row_nxt   = cursor_row_r;
    held_buttons_nxt = held_buttons_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (byte_is_mouse) begin
      unique case (byte_slot_r)
        ps2mpt_pkg::SLOT_XDELTA: x_delta_byte_nxt = in_rx_byte;
        ps2mpt_pkg::SLOT_YDELTA: begin
          cursor_col_nxt   = clamp_coord(nx, screen_width_r);
          cursor_row_nxt   = clamp_coord(ny, screen_height_r);
          held_buttons_nxt = header_byte_r[ps2mpt_pkg::BUTTON_W-1:0];
        end
        default: begin
          if (header_ok) begin
            header_byte_nxt = in_rx_byte;
          end
        end
      endcase
    end
    if (packet_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= ps2mpt_pkg::SCREEN_WIDTH_RESET;
      screen_height_r <= ps2mpt_pkg::SCREEN_HEIGHT_RESET;
      byte_slot_r     <= ps2mpt_pkg::SLOT_HEADER;
      header_byte_r   <= '0;
      x_delta_byte_r  <= '0;
      cursor_col_r    <= '0;
      cursor_row_r    <= '0;
      held_buttons_r  <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ps2mpt_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
          ps2mpt_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      byte_slot_r    <= byte_slot_nxt;
      header_byte_r  <= header_byte_nxt;
      x_delta_byte_r <= x_delta_byte_nxt;
      cursor_col_r   <= cursor_col_nxt;
      cursor_row_r   <= cursor_row_nxt;
      held_buttons_r <= held_buttons_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // The cursor registers always hold the position of the last completed packet,
  // so they serve directly as the result payload.
  assign out_valid       = out_valid_r;
  assign out_pos_x       = cursor_col_r;
  assign out_pos_y       = cursor_row_r;
  assign out_button_bits = held_buttons_r;

endmodule
